>>> rtl/core/mbso_pkg.sv
package mbso_pkg;

  localparam int TABLE_LENGTH = 4096;
  localparam int OVERSAMPLING = 64;

  localparam int FREQ_W     = 23;
  localparam int IDX_W      = 12;
  localparam int TVAL_W     = 18;
  localparam int SAMPLE_W   = 19;
  localparam int SR_W       = 18;
  localparam int PWID_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;
  localparam int RING_W     = 20;
  localparam int PHASE_W    = 32;
  localparam int DIVD_W     = 48;
  localparam int DIVS_W     = 32;

  typedef enum logic [0:0] {
    OP_PRODUCE     = 1'b0,
    OP_TABLE_WRITE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_SAMPLE_RATE = 2'd0,
    REG_PULSE_WIDTH = 2'd1,
    REG_WAVEFORM    = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    DIV_INC  = 2'd0,
    DIV_WRAP = 2'd1,
    DIV_PW   = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     take;
    logic     div_start;
    div_sel_t div_sel;
    logic     inc_commit;
    logic     step_begin;
    logic     step_neg;
    logic     tap_read;
    logic     tap_mul;
    logic     tap_write;
    logic     out_read;
    logic     out_put;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic wrap;
    logic pw_hit;
    logic last_tap;
    logic out_free;
  } status_t;

endpackage

>>> rtl/core/mbso_in_if.sv
interface mbso_in_if;
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic [mbso_pkg::FREQ_W-1:0]         frequency;
  logic [mbso_pkg::IDX_W-1:0]          table_index;
  logic signed [mbso_pkg::TVAL_W-1:0]  table_value;

  modport source(output valid, operation, frequency, table_index, table_value, input ready);
  modport sink(input valid, operation, frequency, table_index, table_value, output ready);
endinterface

>>> rtl/core/mbso_out_if.sv
interface mbso_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mbso_pkg::SAMPLE_W-1:0] sample;

  modport source(output valid, sample, input ready);
  modport sink(input valid, sample, output ready);
endinterface

>>> rtl/core/mbso_cfg_if.sv
interface mbso_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [mbso_pkg::CFG_IDX_W-1:0]    index;
  logic [mbso_pkg::CFG_DATA_W-1:0]   data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/core/mbso_ram.sv
module mbso_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/mbso_div.sv
module mbso_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [mbso_pkg::DIVD_W-1:0] dividend,
  input  logic [mbso_pkg::DIVS_W-1:0] divisor,
  output logic                        done,
  output logic [mbso_pkg::DIVD_W-1:0] quotient
);

  localparam int CW = $clog2(mbso_pkg::DIVD_W);
  localparam logic [CW-1:0] LAST = CW'(mbso_pkg::DIVD_W - 1);

  logic                        busy_r;
  logic                        done_r;
  logic [CW-1:0]               cnt_r;
  logic [mbso_pkg::DIVS_W-1:0] rem_r;
  logic [mbso_pkg::DIVS_W-1:0] den_r;
  logic [mbso_pkg::DIVD_W-1:0] quo_r;
  logic [mbso_pkg::DIVS_W:0]   trial;
  logic [mbso_pkg::DIVS_W:0]   diff;
  logic                        ge;

  assign trial = {rem_r, quo_r[mbso_pkg::DIVD_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == LAST);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == LAST)) begin
        busy_r <= 1'b0;
      end
    end
    if (start) begin
      cnt_r <= '0;
      rem_r <= '0;
      den_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      rem_r <= ge ? diff[mbso_pkg::DIVS_W-1:0] : trial[mbso_pkg::DIVS_W-1:0];
      quo_r <= {quo_r[mbso_pkg::DIVD_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> rtl/core/mbso_datapath.sv
module mbso_datapath #(
  parameter int TABLE_LENGTH = mbso_pkg::TABLE_LENGTH,
  parameter int OVERSAMPLING = mbso_pkg::OVERSAMPLING
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_operation,
  input  logic [mbso_pkg::FREQ_W-1:0]          in_frequency,
  input  logic [mbso_pkg::IDX_W-1:0]           in_table_index,
  input  logic signed [mbso_pkg::TVAL_W-1:0]   in_table_value,
  input  logic                                 cfg_valid,
  input  logic [mbso_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mbso_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic signed [mbso_pkg::SAMPLE_W-1:0] out_sample,
  input  mbso_pkg::cmd_t                       cmd,
  output mbso_pkg::status_t                    st
);

  localparam int TW  = $clog2(TABLE_LENGTH);
  localparam int RS  = TABLE_LENGTH / OVERSAMPLING;
  localparam int RW  = $clog2(RS);
  localparam int OVW = $clog2(OVERSAMPLING + 1);
  localparam int SCW = 16 + OVW;
  localparam int TV  = mbso_pkg::TVAL_W;
  localparam int RNW = mbso_pkg::RING_W;
  localparam int SW  = mbso_pkg::SAMPLE_W;
  localparam logic signed [22:0] RING_MAX = 23'((1 <<< (RNW - 1)) - 1);
  localparam logic signed [22:0] RING_MIN = -23'(1 <<< (RNW - 1));
  localparam logic signed [22:0] SMP_MAX  = 23'((1 <<< (SW - 1)) - 1);
  localparam logic signed [22:0] SMP_MIN  = -23'(1 <<< (SW - 1));

  logic [mbso_pkg::SR_W-1:0]   sr_r;
  logic [mbso_pkg::PWID_W-1:0] pw_r;
  logic                        wave_r;
  logic [mbso_pkg::FREQ_W-1:0] freq_r;
  logic [31:0]                 phase_r;
  logic [31:0]                 inc_r;
  logic                        wrap_r;
  logic                        square_r;
  logic [RW-1:0]               ring_pos_r;
  logic [RW-1:0]               pend_r;
  logic [TW-1:0]               tap_addr_r;
  logic [15:0]                 frac_r;
  logic [RW-1:0]               wpos_r;
  logic [RW-1:0]               k_r;
  logic                        neg_r;
  logic signed [35:0]          prod_r;
  logic                        out_valid_r;
  logic signed [SW-1:0]        sample_r;

  logic [mbso_pkg::DIVD_W-1:0] dividend;
  logic [mbso_pkg::DIVS_W-1:0] divisor;
  logic [mbso_pkg::DIVD_W-1:0] quo;
  logic [31:0]                 pw32;
  logic [31:0]                 inc_sat;
  logic [15:0]                 off;
  logic [SCW-1:0]              scaled;
  logic [32:0]                 sum;
  logic                        tbl_we;
  logic [TV-1:0]               ta;
  logic [TV-1:0]               tb;
  logic [RNW-1:0]              ring_rd;
  logic signed [18:0]          diff;
  logic signed [35:0]          prod_nxt;
  logic signed [35:0]          rounded;
  logic signed [20:0]          f;
  logic signed [21:0]          c;
  logic signed [21:0]          cs;
  logic signed [22:0]          v;
  logic signed [RNW-1:0]       v_sat;
  logic signed [22:0]          w;
  logic signed [SW-1:0]        w_sat;
  logic [RW-1:0]               wpos_inc;
  logic [RW-1:0]               rpos_inc;

  assign pw32 = {pw_r, 16'b0};

  always_comb begin
    case (cmd.div_sel)
      mbso_pkg::DIV_WRAP: begin
        dividend = {phase_r, 16'b0};
        divisor  = inc_r;
      end
      mbso_pkg::DIV_PW: begin
        dividend = {phase_r - pw32, 16'b0};
        divisor  = inc_r;
      end
      default: begin
        dividend = {1'b0, freq_r, 24'b0};
        divisor  = 32'(sr_r);
      end
    endcase
  end

  mbso_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (st.div_done),
    .quotient (quo)
  );

  assign inc_sat = (|quo[47:32]) ? 32'hFFFF_FFFF : quo[31:0];
  assign off     = (|quo[47:16]) ? 16'hFFFF : quo[15:0];
  assign scaled  = SCW'(off) * SCW'(OVERSAMPLING);
  assign sum     = {1'b0, phase_r} + {1'b0, inc_sat};

  assign tbl_we = cmd.take && (in_operation == mbso_pkg::OP_TABLE_WRITE) &&
                  (32'(in_table_index) < 32'(TABLE_LENGTH));

  mbso_ram #(.WIDTH(TV), .DEPTH(TABLE_LENGTH)) u_tbl_a (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (TW'(in_table_index)),
    .wdata (in_table_value),
    .re    (cmd.tap_read),
    .raddr (tap_addr_r),
    .rdata (ta)
  );

  mbso_ram #(.WIDTH(TV), .DEPTH(TABLE_LENGTH)) u_tbl_b (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (TW'(in_table_index)),
    .wdata (in_table_value),
    .re    (cmd.tap_read),
    .raddr (tap_addr_r + 1'b1),
    .rdata (tb)
  );

  mbso_ram #(.WIDTH(RNW), .DEPTH(RS)) u_ring (
    .clk   (clk),
    .we    (cmd.tap_write),
    .waddr (wpos_r),
    .wdata (v_sat),
    .re    (cmd.tap_read || cmd.out_read),
    .raddr (cmd.out_read ? ring_pos_r : wpos_r),
    .rdata (ring_rd)
  );

  assign diff     = $signed({tb[TV-1], tb}) - $signed({ta[TV-1], ta});
  assign prod_nxt = 36'(diff) * 36'($signed({1'b0, frac_r}));
  assign rounded  = (prod_r + 36'sd32768) >>> 16;
  assign f        = 21'($signed(ta)) + rounded[20:0];
  assign c        = 22'sd65536 - 22'(f);
  assign cs       = neg_r ? -c : c;

  always_comb begin
    if (k_r < pend_r) begin
      v = 23'($signed(ring_rd)) + 23'(cs);
    end else begin
      v = 23'(cs);
    end
    if (v > RING_MAX) begin
      v_sat = RING_MAX[RNW-1:0];
    end else if (v < RING_MIN) begin
      v_sat = RING_MIN[RNW-1:0];
    end else begin
      v_sat = v[RNW-1:0];
    end
  end

  always_comb begin
    if (wave_r) begin
      w = square_r ? 23'sd65536 : 23'sd0;
    end else begin
      w = $signed({7'b0, phase_r[31:16]});
    end
    if (pend_r != '0) begin
      w = w + 23'($signed(ring_rd));
    end
    if (w > SMP_MAX) begin
      w_sat = SMP_MAX[SW-1:0];
    end else if (w < SMP_MIN) begin
      w_sat = SMP_MIN[SW-1:0];
    end else begin
      w_sat = w[SW-1:0];
    end
  end

  assign wpos_inc = (wpos_r == RW'(RS - 1)) ? '0 : wpos_r + 1'b1;
  assign rpos_inc = (ring_pos_r == RW'(RS - 1)) ? '0 : ring_pos_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sr_r        <= mbso_pkg::SR_W'(44100);
      pw_r        <= 16'h8000;
      wave_r      <= 1'b0;
      phase_r     <= '0;
      wrap_r      <= 1'b0;
      square_r    <= 1'b0;
      ring_pos_r  <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          mbso_pkg::REG_SAMPLE_RATE: sr_r   <= cfg_data[mbso_pkg::SR_W-1:0];
          mbso_pkg::REG_PULSE_WIDTH: pw_r   <= cfg_data[mbso_pkg::PWID_W-1:0];
          mbso_pkg::REG_WAVEFORM:    wave_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.inc_commit) begin
        phase_r <= sum[31:0];
        wrap_r  <= sum[32];
      end
      if (cmd.step_begin) begin
        square_r <= cmd.step_neg;
      end
      if (cmd.tap_write && st.last_tap) begin
        pend_r <= RW'(RS - 1);
      end
      if (cmd.out_put) begin
        out_valid_r <= 1'b1;
        if (pend_r != '0) begin
          pend_r     <= pend_r - 1'b1;
          ring_pos_r <= rpos_inc;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (cmd.take) begin
      freq_r <= in_frequency;
    end
    if (cmd.inc_commit) begin
      inc_r <= inc_sat;
    end
    if (cmd.step_begin) begin
      tap_addr_r <= TW'(scaled[SCW-1:16]);
      frac_r     <= scaled[15:0];
      wpos_r     <= ring_pos_r;
      k_r        <= '0;
      neg_r      <= cmd.step_neg;
    end
    if (cmd.tap_mul) begin
      prod_r <= prod_nxt;
    end
    if (cmd.tap_write) begin
      wpos_r     <= wpos_inc;
      tap_addr_r <= tap_addr_r + TW'(OVERSAMPLING);
      k_r        <= k_r + 1'b1;
    end
    if (cmd.out_put) begin
      sample_r <= w_sat;
    end
  end

  assign st.wrap     = wrap_r;
  assign st.pw_hit   = !square_r && (phase_r > pw32) && wave_r;
  assign st.last_tap = (k_r == RW'(RS - 2));
  assign st.out_free = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_sample = sample_r;

endmodule

>>> rtl/core/mbso_ctrl.sv
module mbso_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_operation,
  output logic              in_ready,
  output mbso_pkg::cmd_t    cmd,
  input  mbso_pkg::status_t st
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INC_GO,
    S_INC_WAIT,
    S_WRAP_CHK,
    S_PW_CHK,
    S_OFS_WAIT,
    S_TAP_RD,
    S_TAP_MUL,
    S_TAP_WR,
    S_OUT_RD,
    S_OUT_PUT
  } state_t;

  state_t state_r, state_nxt;
  logic   neg_r, neg_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    neg_nxt   = neg_r;
    cmd       = '0;
    cmd.div_sel  = mbso_pkg::DIV_INC;
    cmd.step_neg = neg_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.take = in_valid;
        if (in_valid && (in_operation == mbso_pkg::OP_PRODUCE)) begin
          state_nxt = S_INC_GO;
        end
      end
      S_INC_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_INC_WAIT;
      end
      S_INC_WAIT: begin
        if (st.div_done) begin
          cmd.inc_commit = 1'b1;
          state_nxt      = S_WRAP_CHK;
        end
      end
      S_WRAP_CHK: begin
        if (st.wrap) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = mbso_pkg::DIV_WRAP;
          neg_nxt       = 1'b0;
          state_nxt     = S_OFS_WAIT;
        end else begin
          state_nxt = S_PW_CHK;
        end
      end
      S_PW_CHK: begin
        if (st.pw_hit) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = mbso_pkg::DIV_PW;
          neg_nxt       = 1'b1;
          state_nxt     = S_OFS_WAIT;
        end else begin
          state_nxt = S_OUT_RD;
        end
      end
      S_OFS_WAIT: begin
        if (st.div_done) begin
          cmd.step_begin = 1'b1;
          state_nxt      = S_TAP_RD;
        end
      end
      S_TAP_RD: begin
        cmd.tap_read = 1'b1;
        state_nxt    = S_TAP_MUL;
      end
      S_TAP_MUL: begin
        cmd.tap_mul = 1'b1;
        state_nxt   = S_TAP_WR;
      end
      S_TAP_WR: begin
        cmd.tap_write = 1'b1;
        if (!st.last_tap) begin
          state_nxt = S_TAP_RD;
        end else if (neg_r) begin
          state_nxt = S_OUT_RD;
        end else begin
          state_nxt = S_PW_CHK;
        end
      end
      S_OUT_RD: begin
        cmd.out_read = 1'b1;
        state_nxt    = S_OUT_PUT;
      end
      S_OUT_PUT: begin
        if (st.out_free) begin
          cmd.out_put = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      neg_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      neg_r   <= neg_nxt;
    end
  end

endmodule

>>> rtl/core/minblep_saw_square_oscillator_top.sv
// Band-limited sawtooth and square oscillator with minimum-phase step correction. A table
// write item is taken while idle and leaves the block ready. A produce item computes an
// increment quotient and one more quotient per discontinuity in the sample (a phase wrap, a
// pulse-width crossing or both), then waits for the previous output item to be taken. Each
// quotient comes from the shared bit-serial divider (48 steps, then a completion flag), and
// each discontinuity adds a walk over the 63 step taps in read, multiply and write states.
// The step table must be written before any sample that reads it.
module minblep_saw_square_oscillator_top #(
  parameter int TABLE_LENGTH = mbso_pkg::TABLE_LENGTH,
  parameter int OVERSAMPLING = mbso_pkg::OVERSAMPLING
) (
  input logic        clk,
  input logic        rst_n,
  mbso_in_if.sink    in_ch,
  mbso_out_if.source out_ch,
  mbso_cfg_if.sink   cfg_ch
);

  mbso_pkg::cmd_t    cmd;
  mbso_pkg::status_t st;

  assign cfg_ch.ready = 1'b1;

  mbso_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_operation (in_ch.operation),
    .in_ready     (in_ch.ready),
    .cmd          (cmd),
    .st           (st)
  );

  mbso_datapath #(
    .TABLE_LENGTH (TABLE_LENGTH),
    .OVERSAMPLING (OVERSAMPLING)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_operation   (in_ch.operation),
    .in_frequency   (in_ch.frequency),
    .in_table_index (in_ch.table_index),
    .in_table_value (in_ch.table_value),
    .cfg_valid      (cfg_ch.valid),
    .cfg_index      (cfg_ch.index),
    .cfg_data       (cfg_ch.data),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_sample     (out_ch.sample),
    .cmd            (cmd),
    .st             (st)
  );

  a_table_write_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.operation == mbso_pkg::OP_TABLE_WRITE))
    |=> in_ch.ready)
    else $error("table write item left the block busy");

  a_produce_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.operation == mbso_pkg::OP_PRODUCE))
    |=> !in_ch.ready)
    else $error("produce item did not start work");

  a_output_not_overwritten: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
    else $error("pending output item was lost");

  a_div_not_restarted: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> !cmd.div_start && !cmd.step_begin)
    else $error("divider restarted before finishing");

endmodule
